// ===== rtl/core/mlbd_pkg.sv =====
`timescale 1ns / 1ps

package mlbd_pkg;

  // Default widest source line, in pixels
  localparam int MAX_WIDTH_DEF = 4096;
  // Tallest source level, in rows
  localparam int MAX_HEIGHT = 4096;

  localparam int SIZE_W      = 13;
  localparam int ROW_W       = 12;
  localparam int CH_W        = 8;
  localparam int LANES       = 4;
  localparam int LANE_W      = CH_W + 1;
  localparam int PAIR_W      = LANES * LANE_W;
  localparam int PIX_W       = LANES * CH_W;
  localparam int BLOCK_SHIFT = 2;  // divide by the four pixels of a block

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [PAIR_W-1:0] pair_t;

  // Per-item flags from the scan unit to the result stage
  typedef struct packed {
    logic emit;       // item completes a 2x2 block
    logic from_line;  // upper pair comes from the line store
    logic last;       // final result of the level
  } scan_t;

endpackage

// ===== rtl/core/mlbd_line_store.sv =====
`timescale 1ns / 1ps

module mlbd_line_store #(
  parameter int DEPTH  = mlbd_pkg::MAX_WIDTH_DEF / 2,
  parameter int ADDR_W = 11,
  parameter int DATA_W = mlbd_pkg::PAIR_W
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/mlbd_scan.sv =====
`timescale 1ns / 1ps

module mlbd_scan #(
  parameter int MAX_WIDTH = mlbd_pkg::MAX_WIDTH_DEF,
  parameter int WW        = $clog2(MAX_WIDTH + 1),
  parameter int XW        = $clog2(MAX_WIDTH),
  parameter int ADDR_W    = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic                         accept,
  input  mlbd_pkg::pixel_t             pixel,
  input  logic [WW-1:0]                width,
  input  logic [mlbd_pkg::SIZE_W-1:0]  height,
  output mlbd_pkg::pair_t              pair,
  output mlbd_pkg::scan_t              flags,
  output logic                         line_wr,
  output logic                         line_rd,
  output logic [ADDR_W-1:0]            line_addr
);

  localparam int OXW = (XW > ADDR_W) ? XW : ADDR_W;

  logic [XW-1:0]                 col_r, col_nxt;
  logic [mlbd_pkg::ROW_W-1:0]    row_r, row_nxt;
  mlbd_pkg::pixel_t              left_r;
  logic [WW-1:0]                 col_p1;
  logic [mlbd_pkg::SIZE_W-1:0]   row_p1;
  logic [WW-1:0]                 ox, ow_m1;
  logic [mlbd_pkg::SIZE_W-1:0]   oy, oh_m1;
  logic [OXW-1:0]                ox_ext;
  logic                          w_one, h_one, have_pair;
  mlbd_pkg::pixel_t              pair_a;

  function automatic mlbd_pkg::pair_t pair_add(mlbd_pkg::pixel_t a, mlbd_pkg::pixel_t b);
    mlbd_pkg::pair_t r;
    r = '0;
    for (int c = 0; c < mlbd_pkg::LANES; c++) begin
      r[c*mlbd_pkg::LANE_W +: mlbd_pkg::LANE_W] =
        {1'b0, a[c*mlbd_pkg::CH_W +: mlbd_pkg::CH_W]} +
        {1'b0, b[c*mlbd_pkg::CH_W +: mlbd_pkg::CH_W]};
    end
    return r;
  endfunction

  assign w_one  = (width == WW'(1));
  assign h_one  = (height == mlbd_pkg::SIZE_W'(1));
  assign col_p1 = WW'(col_r) + WW'(1);
  assign row_p1 = mlbd_pkg::SIZE_W'(row_r) + mlbd_pkg::SIZE_W'(1);

  // Width one pairs the pixel with itself; otherwise odd columns close a pair
  assign have_pair = w_one | col_r[0];
  assign pair_a    = w_one ? pixel : left_r;
  assign pair      = pair_add(pair_a, pixel);

  assign ox     = WW'(col_r >> 1);
  assign oy     = mlbd_pkg::SIZE_W'(row_r >> 1);
  assign ow_m1  = w_one ? '0 : (width >> 1) - WW'(1);
  assign oh_m1  = h_one ? '0 : (height >> 1) - mlbd_pkg::SIZE_W'(1);
  assign ox_ext = OXW'(col_r >> 1);
  assign line_addr = ox_ext[ADDR_W-1:0];

  always_comb begin
    flags.emit      = 1'b0;
    flags.from_line = 1'b0;
    flags.last      = (ox == ow_m1) && (oy == oh_m1);
    line_wr         = 1'b0;
    line_rd         = 1'b0;
    if (have_pair) begin
      if (h_one) begin
        flags.emit = 1'b1;
      end else if (!row_r[0]) begin
        // Dropped last row of an odd height leaves no pair sums
        line_wr = accept && (row_p1 < height);
      end else begin
        flags.emit      = 1'b1;
        flags.from_line = 1'b1;
        line_rd         = accept;
      end
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_p1 >= width) begin
        col_nxt = '0;
        row_nxt = (row_p1 >= height) ? '0 : row_p1[mlbd_pkg::ROW_W-1:0];
      end else begin
        col_nxt = col_p1[XW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (accept && !w_one && !col_r[0] && (col_p1 < width)) begin
      left_r <= pixel;
    end
  end

endmodule

// ===== rtl/core/mip_level_box_downsample.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Signals                                     Transfer when
// in       input      in_pixel_red/green/blue/alpha                in_valid & in_ready
// out      output     out_red/green/blue/alpha, out_last_of_level  out_valid & out_ready
// cfg      input      cfg_index, cfg_data                          cfg_valid & cfg_ready
//
// One source pixel per clock while in_ready is high; the pixel that completes
// a 2x2 block passes through the scan stage, then the result register.
// The line store has one port, read or written at most once per pixel transfer.
// Reset clears counters and the held left pixel and sets the size registers to 1 x 1;
// the line store is not cleared.
// A stalled out channel holds the result register; at most one more pixel is
// taken into the scan stage, then in_ready drops. cfg_ready is always high.

module mip_level_box_downsample #(
  parameter int MAX_WIDTH = mlbd_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mlbd_pkg::CH_W-1:0]         in_pixel_red,
  input  logic [mlbd_pkg::CH_W-1:0]         in_pixel_green,
  input  logic [mlbd_pkg::CH_W-1:0]         in_pixel_blue,
  input  logic [mlbd_pkg::CH_W-1:0]         in_pixel_alpha,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mlbd_pkg::CH_W-1:0]         out_red,
  output logic [mlbd_pkg::CH_W-1:0]         out_green,
  output logic [mlbd_pkg::CH_W-1:0]         out_blue,
  output logic [mlbd_pkg::CH_W-1:0]         out_alpha,
  output logic                              out_last_of_level,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mlbd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mlbd_pkg::SIZE_W-1:0]       cfg_data
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int CMP_W      = (WW > mlbd_pkg::SIZE_W) ? WW : mlbd_pkg::SIZE_W;
  localparam int SUM_W      = mlbd_pkg::LANE_W + 1;

  logic [mlbd_pkg::SIZE_W-1:0] src_width_r, src_height_r;
  logic                        cfg_xfer, cfg_hit;
  logic [WW-1:0]               width_eff;
  logic [mlbd_pkg::SIZE_W-1:0] height_eff;

  logic                        in_xfer;
  mlbd_pkg::pixel_t            pixel;
  mlbd_pkg::pair_t             pair;
  mlbd_pkg::scan_t             flags;
  logic                        line_wr, line_rd;
  logic [ADDR_W-1:0]           line_addr;
  mlbd_pkg::pair_t             line_data;

  logic                        s1_valid_r, s1_valid_nxt, s1_adv;
  mlbd_pkg::pair_t             s1_pair_r;
  mlbd_pkg::scan_t             s1_flags_r;
  mlbd_pkg::pair_t             upper;
  mlbd_pkg::pixel_t            mean;

  logic                        out_valid_r, out_valid_nxt;
  mlbd_pkg::pixel_t            out_pix_r;
  logic                        out_last_r;

  // Configuration: any write to a listed register restarts the level
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_xfer &&
                     ((cfg_index == mlbd_pkg::REG_SRC_WIDTH) ||
                      (cfg_index == mlbd_pkg::REG_SRC_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= mlbd_pkg::SIZE_W'(1);
      src_height_r <= mlbd_pkg::SIZE_W'(1);
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        mlbd_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_data;
        mlbd_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero acts as one, oversize clamps to the line store and height limits
  always_comb begin
    if (src_width_r == '0) begin
      width_eff = WW'(1);
    end else if (CMP_W'(src_width_r) > CMP_W'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(src_width_r);
    end
    if (src_height_r == '0) begin
      height_eff = mlbd_pkg::SIZE_W'(1);
    end else if (src_height_r > mlbd_pkg::SIZE_W'(mlbd_pkg::MAX_HEIGHT)) begin
      height_eff = mlbd_pkg::SIZE_W'(mlbd_pkg::MAX_HEIGHT);
    end else begin
      height_eff = src_height_r;
    end
  end

  // Advance the scan stage whenever the result register is free or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;
  assign pixel    = {in_pixel_alpha, in_pixel_blue, in_pixel_green, in_pixel_red};

  mlbd_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .WW        (WW),
    .XW        (XW),
    .ADDR_W    (ADDR_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_hit),
    .accept    (in_xfer),
    .pixel     (pixel),
    .width     (width_eff),
    .height    (height_eff),
    .pair      (pair),
    .flags     (flags),
    .line_wr   (line_wr),
    .line_rd   (line_rd),
    .line_addr (line_addr)
  );

  mlbd_line_store #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (mlbd_pkg::PAIR_W)
  ) u_line (
    .clk     (clk),
    .wr_en   (line_wr),
    .rd_en   (line_rd),
    .addr    (line_addr),
    .wr_data (pair),
    .rd_data (line_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pair_r  <= pair;
      s1_flags_r <= flags;
    end
  end

  // Add the upper pair sums and drop the two low bits of each lane
  assign upper = s1_flags_r.from_line ? line_data : s1_pair_r;

  always_comb begin
    logic [SUM_W-1:0] s;
    mean = '0;
    for (int c = 0; c < mlbd_pkg::LANES; c++) begin
      s = {1'b0, s1_pair_r[c*mlbd_pkg::LANE_W +: mlbd_pkg::LANE_W]} +
          {1'b0, upper[c*mlbd_pkg::LANE_W +: mlbd_pkg::LANE_W]};
      mean[c*mlbd_pkg::CH_W +: mlbd_pkg::CH_W] =
        s[mlbd_pkg::BLOCK_SHIFT +: mlbd_pkg::CH_W];
    end
  end

  // Items that complete no block are dropped as they leave the scan stage
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_flags_r.emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags_r.emit) begin
      out_pix_r  <= mean;
      out_last_r <= s1_flags_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red           = out_pix_r[0*mlbd_pkg::CH_W +: mlbd_pkg::CH_W];
  assign out_green         = out_pix_r[1*mlbd_pkg::CH_W +: mlbd_pkg::CH_W];
  assign out_blue          = out_pix_r[2*mlbd_pkg::CH_W +: mlbd_pkg::CH_W];
  assign out_alpha         = out_pix_r[3*mlbd_pkg::CH_W +: mlbd_pkg::CH_W];
  assign out_last_of_level = out_last_r;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Bench for the 2x2 box-filter mip downsampler.
//
// A queue of source pixels feeds a clocked driver; every pixel transfer runs
// through a local box-filter predictor that keeps its own size registers,
// scan position, held left pixel and pair-sum line. Predicted block means
// wait in a queue. A clocked monitor pops one per result transfer and checks
// each channel and the level flag.
//
// Size registers change only while the block is idle.

module tb;

  localparam int MAX_WIDTH_DEF = mlbd_pkg::MAX_WIDTH_DEF;
  localparam int MAX_HEIGHT    = mlbd_pkg::MAX_HEIGHT;
  localparam int SIZE_W        = mlbd_pkg::SIZE_W;
  localparam int CH_W          = mlbd_pkg::CH_W;
  localparam int LANES         = mlbd_pkg::LANES;
  localparam int LANE_W        = mlbd_pkg::LANE_W;
  localparam int BLOCK_SHIFT   = mlbd_pkg::BLOCK_SHIFT;
  localparam int CFG_INDEX_W   = mlbd_pkg::CFG_INDEX_W;

  localparam int LINE_DEPTH = MAX_WIDTH_DEF / 2;

  // Indexes past the register list: the block must ignore these writes
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    mlbd_pkg::pixel_t rgba;         // red in the low byte, alpha in the high byte
    logic             drain_first;  // hold this pixel back until every mean has come
  } src_pixel_t;

  typedef struct packed {
    mlbd_pkg::pixel_t rgba;
    logic             last;
  } block_mean_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CH_W-1:0]    in_pixel_red = '0;
  logic [CH_W-1:0]    in_pixel_green = '0;
  logic [CH_W-1:0]    in_pixel_blue = '0;
  logic [CH_W-1:0]    in_pixel_alpha = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic [CH_W-1:0]    out_red;
  logic [CH_W-1:0]    out_green;
  logic [CH_W-1:0]    out_blue;
  logic [CH_W-1:0]    out_alpha;
  logic               out_last_of_level;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]  cfg_data = '0;

  // Predictor state
  mlbd_pkg::pair_t   pair_line [LINE_DEPTH];
  mlbd_pkg::pixel_t  held_left = '0;
  int unsigned       scan_x = 0;
  int unsigned       scan_y = 0;
  logic [SIZE_W-1:0] width_reg = SIZE_W'(1);
  logic [SIZE_W-1:0] height_reg = SIZE_W'(1);

  src_pixel_t  src_pixel_q[$];
  block_mean_t block_mean_q[$];
  src_pixel_t  cur_pixel;
  logic        pixel_pending = 1'b0;
  block_mean_t want;
  idle_mode_t  idle_mode = IDLE_NONE;

  int unsigned n_pixels = 0;
  int unsigned n_means = 0;
  int unsigned n_cfg = 0;
  int unsigned n_errors = 0;

  mip_level_box_downsample #(
    .MAX_WIDTH(MAX_WIDTH_DEF)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_red      (in_pixel_red),
    .in_pixel_green    (in_pixel_green),
    .in_pixel_blue     (in_pixel_blue),
    .in_pixel_alpha    (in_pixel_alpha),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_alpha         (out_alpha),
    .out_last_of_level (out_last_of_level),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Box-filter predictor
  // ---------------------------------------------------------------------

  // Zero acts as one, oversize clamps to the largest supported size
  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Four 9-bit lane sums of two pixels, red lane lowest
  function automatic mlbd_pkg::pair_t pair_sums(mlbd_pkg::pixel_t a, mlbd_pkg::pixel_t b);
    mlbd_pkg::pair_t r;
    r = '0;
    for (int c = 0; c < LANES; c++)
      r[c*LANE_W +: LANE_W] = LANE_W'(a[c*CH_W +: CH_W]) + LANE_W'(b[c*CH_W +: CH_W]);
    return r;
  endfunction

  // Advance the predictor by one source pixel; queue a mean when a block closes
  task automatic box_filter_step(mlbd_pkg::pixel_t pix);
    int unsigned     w, h, ow, oh, x, y, ox, oy, s;
    mlbd_pkg::pair_t pair, upper;
    logic            have_pair, emit;
    block_mean_t     m;
    w = eff_size(width_reg, MAX_WIDTH_DEF);
    h = eff_size(height_reg, MAX_HEIGHT);
    ow = (w > 1) ? w / 2 : 1;
    oh = (h > 1) ? h / 2 : 1;
    x = (scan_x >= w) ? 0 : scan_x;
    y = (scan_y >= h) ? 0 : scan_y;
    pair = '0;
    upper = '0;
    have_pair = 1'b0;
    emit = 1'b0;
    ox = 0;
    oy = y / 2;

    // Horizontal pairing: width 1 pairs a pixel with itself
    if (w == 1) begin
      pair = pair_sums(pix, pix);
      have_pair = 1'b1;
    end else if (x % 2 == 0) begin
      if (x + 1 < w) held_left = pix;
    end else begin
      pair = pair_sums(held_left, pix);
      ox = x / 2;
      have_pair = 1'b1;
    end

    // Vertical pairing: height 1 closes a block at once; else even rows store, odd rows close the block
    if (have_pair && ox < LINE_DEPTH) begin
      if (h == 1) begin
        upper = pair;
        oy = 0;
        emit = 1'b1;
      end else if (y % 2 == 0) begin
        if (y + 1 < h) pair_line[ox] = pair;
      end else begin
        upper = pair_line[ox];
        emit = 1'b1;
      end
    end

    if (emit) begin
      for (int c = 0; c < LANES; c++) begin
        s = pair[c*LANE_W +: LANE_W] + upper[c*LANE_W +: LANE_W];
        m.rgba[c*CH_W +: CH_W] = CH_W'(s >> BLOCK_SHIFT);
      end
      m.last = (ox == ow - 1) && (oy == oh - 1);
      block_mean_q = {block_mean_q, m};
    end

    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    scan_x = x;
    scan_y = y;
  endtask

  // A write to a listed register restarts the level; other indexes do nothing
  function automatic void apply_cfg(logic [CFG_INDEX_W-1:0] idx, logic [SIZE_W-1:0] val);
    case (idx)
      mlbd_pkg::REG_SRC_WIDTH: begin
        width_reg = val;
        scan_x = 0;
        scan_y = 0;
      end
      mlbd_pkg::REG_SRC_HEIGHT: begin
        height_reg = val;
        scan_x = 0;
        scan_y = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic logic sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 83;
      IDLE_BOTH:   return $urandom_range(99) < 31;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 83;
      IDLE_BOTH:     return $urandom_range(99) < 31;
      default:       return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Pixel driver
  // ---------------------------------------------------------------------
  // On a pixel transfer, run the predictor. Load the next pixel only when the
  // channel is free; hold valid and payload while the block stalls. A pixel
  // marked drain_first waits until no mean is outstanding.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        box_filter_step(cur_pixel.rgba);
        pixel_pending = 1'b0;
        n_pixels++;
      end
      if (!in_valid || in_ready) begin
        if (src_pixel_q.size() != 0 && !sender_gap() &&
            !(src_pixel_q[0].drain_first && block_mean_q.size() != 0)) begin
          cur_pixel = src_pixel_q.pop_front();
          pixel_pending = 1'b1;
          in_valid <= 1'b1;
          in_pixel_red   <= cur_pixel.rgba[0*CH_W +: CH_W];
          in_pixel_green <= cur_pixel.rgba[1*CH_W +: CH_W];
          in_pixel_blue  <= cur_pixel.rgba[2*CH_W +: CH_W];
          in_pixel_alpha <= cur_pixel.rgba[3*CH_W +: CH_W];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------
  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      n_errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Compare every result transfer against the oldest predicted mean, then
  // pick the ready level for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (block_mean_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: expected none, actual r%0d g%0d b%0d a%0d last%0d",
                 $time, out_red, out_green, out_blue, out_alpha, out_last_of_level);
      end else begin
        want = block_mean_q.pop_front();
        n_means++;
        check_field("out_red",   want.rgba[0*CH_W +: CH_W], out_red);
        check_field("out_green", want.rgba[1*CH_W +: CH_W], out_green);
        check_field("out_blue",  want.rgba[2*CH_W +: CH_W], out_blue);
        check_field("out_alpha", want.rgba[3*CH_W +: CH_W], out_alpha);
        check_field("out_last_of_level", want.last, out_last_of_level);
      end
    end
    out_ready <= !receiver_stall();
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Wait until nothing is queued, presented or outstanding, then let the
  // pipeline flush pixels that close no block.
  task automatic wait_idle();
    @(posedge clk);
    while (src_pixel_q.size() != 0 || pixel_pending || block_mean_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [SIZE_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_cfg(idx, val);
    n_cfg++;
  endtask

  task automatic set_size(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    write_reg(mlbd_pkg::REG_SRC_WIDTH, w);
    write_reg(mlbd_pkg::REG_SRC_HEIGHT, h);
  endtask

  task automatic push_rgba(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                           logic [CH_W-1:0] b, logic [CH_W-1:0] a, logic drain);
    src_pixel_t p;
    p.rgba = {a, b, g, r};
    p.drain_first = drain;
    src_pixel_q = {src_pixel_q, p};
  endtask

  // Channels lean toward the extremes so saturated sums show up often
  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  task automatic push_random(int unsigned count);
    repeat (count)
      push_rgba(rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                $urandom_range(99) < 2);
  endtask

  // Random levels: mostly whole levels of small size, some split by an
  // ignored register write, some cut short by the next size change.
  task automatic random_levels(int unsigned budget);
    int unsigned sent, w, h, total, levels, cut, pick;
    sent = 0;
    while (sent < budget) begin
      w = ($urandom_range(99) < 6) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(99) < 20) w = $urandom_range(9, 40);
      h = ($urandom_range(99) < 6) ? 0 : $urandom_range(1, 8);
      if (w > 8) h = $urandom_range(1, 4);
      else if ($urandom_range(99) < 10) h = $urandom_range(9, 24);

      pick = $urandom_range(99);
      if (pick < 35) begin
        set_size(SIZE_W'(w), SIZE_W'(h));
      end else if (pick < 70) begin
        write_reg(mlbd_pkg::REG_SRC_HEIGHT, SIZE_W'(h));
        write_reg(mlbd_pkg::REG_SRC_WIDTH, SIZE_W'(w));
      end else if (pick < 85) begin
        write_reg(mlbd_pkg::REG_SRC_WIDTH, SIZE_W'(w));
      end else begin
        write_reg(mlbd_pkg::REG_SRC_HEIGHT, SIZE_W'(h));
      end
      total = eff_size(width_reg, MAX_WIDTH_DEF) * eff_size(height_reg, MAX_HEIGHT);

      levels = $urandom_range(1, 3);
      repeat (levels) begin
        if (total > 1 && $urandom_range(99) < 8) begin
          cut = $urandom_range(1, total - 1);
          push_random(cut);
          write_reg($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3, SIZE_W'($urandom()));
          push_random(total - cut);
        end else begin
          push_random(total);
        end
        sent += total;
      end

      // Broken level: the next size write restarts the scan
      if ($urandom_range(99) < 12) begin
        cut = $urandom_range(1, total);
        push_random(cut);
        sent += cut;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset size is 1 x 1: every pixel is its own mean and ends the level
    push_rgba('1, '1, '1, '1, 1'b0);
    push_rgba('0, '0, '0, '0, 1'b0);
    push_rgba(8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b0);

    // Zero sizes act as one
    set_size('0, '0);
    push_random(1);

    // Largest lane sums, then truncation of small ones
    set_size(SIZE_W'(2), SIZE_W'(2));
    repeat (4) push_rgba('1, '1, '1, '1, 1'b0);
    push_rgba(8'd1, 8'd2, 8'd3, 8'd0, 1'b0);
    push_rgba(8'd0, 8'd1, 8'd0, 8'd3, 1'b0);

    // Writes past the register list must not restart the level
    write_reg(REG_UNUSED_2, '1);
    write_reg(REG_UNUSED_3, '0);
    push_rgba(8'd1, 8'd0, 8'd0, 8'd0, 1'b0);
    push_rgba(8'd0, 8'd0, 8'd0, 8'd1, 1'b0);

    // Odd size: drop the last column and row; hold one pixel for a full drain
    set_size(SIZE_W'(3), SIZE_W'(3));
    push_random(4);
    push_rgba(8'h80, 8'h7F, 8'h01, 8'hFE, 1'b1);
    push_random(4);

    // Single column doubles horizontally, single row doubles vertically
    set_size(SIZE_W'(1), SIZE_W'(2));
    push_random(2);
    set_size(SIZE_W'(5), SIZE_W'(1));
    push_random(5);

    // Oversize width clamps to the full line; run the start of a single row
    set_size('1, SIZE_W'(1));
    push_random(48);

    // Oversize height: run a few rows, then cut the level with a new size
    set_size(SIZE_W'(2), '1);
    push_random(16);

    // Random phases, one per idle pattern
    random_levels(400);
    idle_mode = IDLE_SENDER;
    random_levels(400);
    idle_mode = IDLE_RECEIVER;
    random_levels(400);
    idle_mode = IDLE_BOTH;
    random_levels(400);

    wait_idle();
    repeat (6) @(posedge clk);

    $display("Covered %0d source pixels and %0d block means over %0d register writes,",
             n_pixels, n_means, n_cfg);
    $display("with clamped and zero sizes, odd drops and four idle patterns; %0d errors.",
             n_errors);
    if (n_errors == 0) begin
      $display("mip_level_box_downsample regression: pass");
    end else begin
      $display("mip_level_box_downsample regression: fail");
    end
    $finish;
  end

  // Watchdog: a run far past its slowest legal length is a hang
  initial begin
    #10ms;
    $display("mip_level_box_downsample regression: fail");
    $finish;
  end

endmodule
